// ===== hw/rtl/frc16_pkg.sv =====
// shared types, constants and the crc-16 byte update for the framed byte receiver
// no dependencies
`default_nettype none

package frc16_pkg;

  localparam logic [7:0]  STX_BYTE   = 8'hAA;
  localparam logic [7:0]  ETX_BYTE   = 8'h55;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  KEY_TYPE   = 8'h10;
  localparam logic [1:0]  ETX_NEEDED = 2'd3;
  localparam int          MIN_FRAME  = 6;
  localparam int          TAIL_LEN   = 5;
  localparam int          PAY_LEN    = 8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [7:0]  message_type;
    logic [6:0]  frame_length;
    logic        is_key_frame;
    logic [31:0] key_value;
    logic [7:0]  slider_a;
    logic [7:0]  slider_b;
    logic [7:0]  slider_c;
    logic [7:0]  slider_d;
  } frc16_result_t;

  // crc-16, msb first, one byte unrolled
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frc16_if.sv =====
// valid/ready channel interfaces for the received bytes and the frame reports
// no dependencies
`default_nettype none

interface frc16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface frc16_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  message_type;
  logic [6:0]  frame_length;
  logic        is_key_frame;
  logic [31:0] key_value;
  logic [7:0]  slider_a;
  logic [7:0]  slider_b;
  logic [7:0]  slider_c;
  logic [7:0]  slider_d;
  modport source (output valid, output frame_status, output message_type,
                  output frame_length, output is_key_frame, output key_value,
                  output slider_a, output slider_b, output slider_c, output slider_d,
                  input ready);
  modport sink (input valid, input frame_status, input message_type,
                input frame_length, input is_key_frame, input key_value,
                input slider_a, input slider_b, input slider_c, input slider_d,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/frc16_parser.sv =====
// frame state, crc accumulation, tail delay line and report builder, one byte per beat
// depends on frc16_pkg
`default_nettype none

module frc16_parser #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [7:0]               in_byte,
  input  wire logic                     in_ready,
  output logic                          done,
  output frc16_pkg::frc16_result_t      res
);
  import frc16_pkg::*;

  localparam int LenCap = (MAX_FRAME < 127) ? MAX_FRAME : 127;

  logic        in_frame_r, in_frame_nxt;
  logic [1:0]  etx_run_r, etx_run_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  tail_r [TAIL_LEN];
  logic [7:0]  tail_nxt [TAIL_LEN];
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  pay_r [PAY_LEN];
  logic [7:0]  pay_nxt [PAY_LEN];
  logic        ovf_r, ovf_nxt;

  logic        accept;
  logic        start;
  logic        active;
  logic [1:0]  etx_c;
  logic [6:0]  cnt_c;
  logic [15:0] crc_c;
  logic [7:0]  tail_c [TAIL_LEN];
  logic [7:0]  type_c;
  logic [7:0]  pay_c [PAY_LEN];
  logic        ovf_c;
  logic [1:0]  etx_upd;
  logic [2:0]  pay_idx;
  logic [1:0]  status;
  logic        key;

  assign accept = in_valid & in_ready;
  assign start  = ~in_frame_r & (in_byte == STX_BYTE);
  assign active = in_frame_r | start;

  always_comb begin
    // a frame-opening stx sees cleared frame state
    etx_c  = start ? 2'd0 : etx_run_r;
    cnt_c  = start ? 7'd0 : cnt_r;
    crc_c  = start ? 16'd0 : crc_r;
    type_c = start ? 8'd0 : type_r;
    ovf_c  = start ? 1'b0 : ovf_r;
    for (int i = 0; i < TAIL_LEN; i++) tail_c[i] = start ? 8'd0 : tail_r[i];
    for (int i = 0; i < PAY_LEN; i++) pay_c[i] = start ? 8'd0 : pay_r[i];

    type_nxt = (cnt_c == 7'd1) ? in_byte : type_c;
    pay_idx  = 3'(cnt_c - 7'd2);
    for (int i = 0; i < PAY_LEN; i++) pay_nxt[i] = pay_c[i];
    if (cnt_c >= 7'd2 && cnt_c < 7'(2 + PAY_LEN)) pay_nxt[pay_idx] = in_byte;

    crc_nxt = (cnt_c >= 7'(TAIL_LEN)) ? crc16_byte(crc_c, tail_c[0]) : crc_c;
    for (int i = 0; i < TAIL_LEN - 1; i++) tail_nxt[i] = tail_c[i + 1];
    tail_nxt[TAIL_LEN - 1] = in_byte;

    if (cnt_c < 7'(LenCap)) begin
      cnt_nxt = cnt_c + 7'd1;
      ovf_nxt = ovf_c;
    end else begin
      cnt_nxt = cnt_c;
      ovf_nxt = 1'b1;
    end

    if (in_byte == ETX_BYTE) begin
      etx_upd = (etx_c < ETX_NEEDED) ? etx_c + 2'd1 : etx_c;
    end else begin
      etx_upd = 2'd0;
    end

    done = accept & active & (etx_upd == ETX_NEEDED);

    in_frame_nxt = (active && etx_upd != ETX_NEEDED);
    etx_run_nxt  = (etx_upd == ETX_NEEDED) ? 2'd0 : etx_upd;

    if (ovf_nxt) begin
      status = ST_OVERFLOW;
    end else if (cnt_nxt < 7'(MIN_FRAME)) begin
      status = ST_SHORT;
    end else if ({tail_nxt[0], tail_nxt[1]} != crc_nxt) begin
      status = ST_CRC_BAD;
    end else begin
      status = ST_OK;
    end
    key = (status == ST_OK) && (type_nxt == KEY_TYPE);

    res.frame_status = status;
    res.message_type = type_nxt;
    res.frame_length = cnt_nxt;
    res.is_key_frame = key;
    res.key_value    = key ? {pay_nxt[3], pay_nxt[2], pay_nxt[1], pay_nxt[0]} : 32'd0;
    res.slider_a     = key ? pay_nxt[4] : 8'd0;
    res.slider_b     = key ? pay_nxt[5] : 8'd0;
    res.slider_c     = key ? pay_nxt[6] : 8'd0;
    res.slider_d     = key ? pay_nxt[7] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      etx_run_r  <= 2'd0;
      cnt_r      <= 7'd0;
      crc_r      <= 16'd0;
      type_r     <= 8'd0;
      ovf_r      <= 1'b0;
      for (int i = 0; i < TAIL_LEN; i++) tail_r[i] <= 8'd0;
      for (int i = 0; i < PAY_LEN; i++) pay_r[i] <= 8'd0;
    end else if (accept && active) begin
      in_frame_r <= in_frame_nxt;
      etx_run_r  <= etx_run_nxt;
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
      type_r     <= type_nxt;
      ovf_r      <= ovf_nxt;
      for (int i = 0; i < TAIL_LEN; i++) tail_r[i] <= tail_nxt[i];
      for (int i = 0; i < PAY_LEN; i++) pay_r[i] <= pay_nxt[i];
    end
  end

  a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !in_frame_r && etx_run_r == 2'd0)
    else $error("frame still open after terminator");

  a_key_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    done && res.is_key_frame |-> res.frame_status == ST_OK && res.message_type == KEY_TYPE)
    else $error("key report on a bad frame");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 7'(LenCap))
    else $error("byte count past cap");

  a_ovf_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> cnt_r == 7'(LenCap))
    else $error("overflow flag without full count");

endmodule

`default_nettype wire

// ===== hw/rtl/frc16_outbuf.sv =====
// two-entry report buffer: output register plus skid slot
// depends on frc16_pkg and frc16_out_if
`default_nettype none

module frc16_outbuf (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push_valid,
  input  wire frc16_pkg::frc16_result_t push_res,
  output logic                          push_ready,
  frc16_out_if.source                   out_ch
);
  import frc16_pkg::*;

  frc16_result_t out_r, skid_r;
  logic          out_v_r, skid_v_r;

  assign push_ready = ~skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push_valid;
      end
    end else if (push_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skid_v_r ? skid_r : push_res;
    end else if (push_valid && !skid_v_r) begin
      skid_r <= push_res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.frame_status = out_r.frame_status;
  assign out_ch.message_type = out_r.message_type;
  assign out_ch.frame_length = out_r.frame_length;
  assign out_ch.is_key_frame = out_r.is_key_frame;
  assign out_ch.key_value    = out_r.key_value;
  assign out_ch.slider_a     = out_r.slider_a;
  assign out_ch.slider_b     = out_r.slider_b;
  assign out_ch.slider_c     = out_r.slider_c;
  assign out_ch.slider_d     = out_r.slider_d;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full with output empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push_valid)
    else $error("report pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_ch.ready |=> !skid_v_r && out_v_r)
    else $error("skid slot did not move forward");

endmodule

`default_nettype wire

// ===== hw/rtl/frame_receiver_crc16_check_top.sv =====
// framed byte receiver with crc-16 check, top level
// depends on frc16_pkg, frc16_if, frc16_parser, frc16_outbuf
//
// in_ch carries one received byte per beat. outside a frame every byte but
// stx (0xaa) is dropped; a frame runs from stx to the third consecutive etx
// (0x55). the two bytes before the etx run are the received crc-16 (poly 0x1021,
// init 0), checked against the crc of the earlier frame bytes.
// out_ch carries one report beat per terminated frame: status, message type,
// length and, for a good key frame (type 0x10), the key word and four sliders.
// bytes that end no frame produce no beat.
// a byte is taken every cycle while in_ch ready is high; the report is registered
// or held in the skid slot while out_ch stalls. the per-byte crc update of the
// delay line output and the frame checks sit in one register-to-register stage.
// reset clears all frame state and drops any pending reports.
// when out_ch stalls, one more report is held in a skid slot; in_ch ready drops
// only while both report slots are full.
`default_nettype none

module frame_receiver_crc16_check_top #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  frc16_in_if.sink     in_ch,
  frc16_out_if.source  out_ch
);
  import frc16_pkg::*;

  logic          done;
  logic          in_ready;
  frc16_result_t res;

  assign in_ch.ready = in_ready;

  frc16_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .in_ready (in_ready),
    .done     (done),
    .res      (res)
  );

  frc16_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (done),
    .push_res   (res),
    .push_ready (in_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== bench/frame_receiver_crc16_check_top_tb.sv =====
// self-checking bench for frame_receiver_crc16_check_top: framed byte stream in, frame reports out
// depends on frc16_pkg and frc16_if from the rtl; a local frame tracker predicts every report
// directed frames first, then random well-formed, broken and overlong frames under random stalls

module frame_receiver_crc16_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frc16_pkg::*;

  localparam int MAX_FRAME    = 64;
  localparam int LEN_CAP      = (MAX_FRAME < 127) ? MAX_FRAME : 127;
  localparam int RANDOM_BYTES = 1400;
  localparam int PARK_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frc16_in_if  in_ch ();
  frc16_out_if out_ch ();

  frame_receiver_crc16_check_top #(
    .MAX_FRAME(MAX_FRAME)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frc16_result_t expected_reports[$];
  logic [7:0]    tx_bytes[$];
  int            errors = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  bit            park_request = 1'b0;

  // frame tracker state
  bit          in_msg = 1'b0;
  int          etx_streak = 0;
  int          msg_len = 0;
  logic [15:0] run_crc = '0;
  logic [7:0]  tail_bytes[TAIL_LEN];
  logic [7:0]  msg_type_q = '0;
  logic [7:0]  payload_q[PAY_LEN];
  bit          too_long = 1'b0;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ data[i];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic void restart_msg();
    etx_streak = 0;
    msg_len    = 0;
    run_crc    = '0;
    msg_type_q = '0;
    too_long   = 1'b0;
    foreach (tail_bytes[i]) tail_bytes[i] = '0;
    foreach (payload_q[i]) payload_q[i] = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    frc16_result_t rep;
    logic [15:0]   rx_crc;
    if (!in_msg) begin
      if (b != STX_BYTE) return;
      restart_msg();
      in_msg = 1'b1;
    end
    if (msg_len == 1) msg_type_q = b;
    else if (msg_len >= 2 && msg_len < 2 + PAY_LEN) payload_q[msg_len - 2] = b;
    // the byte leaving the tail enters the crc
    if (msg_len >= TAIL_LEN) run_crc = crc_step(run_crc, tail_bytes[0]);
    for (int i = 0; i < TAIL_LEN - 1; i++) tail_bytes[i] = tail_bytes[i + 1];
    tail_bytes[TAIL_LEN - 1] = b;
    if (msg_len < LEN_CAP) msg_len++;
    else too_long = 1'b1;
    if (b == ETX_BYTE) begin
      if (etx_streak < ETX_NEEDED) etx_streak++;
    end else begin
      etx_streak = 0;
    end
    if (etx_streak < ETX_NEEDED) return;

    rx_crc = {tail_bytes[0], tail_bytes[1]};
    if (too_long) rep.frame_status = ST_OVERFLOW;
    else if (msg_len < MIN_FRAME) rep.frame_status = ST_SHORT;
    else if (rx_crc != run_crc) rep.frame_status = ST_CRC_BAD;
    else rep.frame_status = ST_OK;
    rep.message_type = msg_type_q;
    rep.frame_length = 7'(msg_len);
    rep.is_key_frame = (rep.frame_status == ST_OK) && (msg_type_q == KEY_TYPE);
    rep.key_value    = rep.is_key_frame ?
                       {payload_q[3], payload_q[2], payload_q[1], payload_q[0]} : '0;
    rep.slider_a     = rep.is_key_frame ? payload_q[4] : '0;
    rep.slider_b     = rep.is_key_frame ? payload_q[5] : '0;
    rep.slider_c     = rep.is_key_frame ? payload_q[6] : '0;
    rep.slider_d     = rep.is_key_frame ? payload_q[7] : '0;
    expected_reports.push_back(rep);
    in_msg     = 1'b0;
    etx_streak = 0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_report();
    frc16_result_t want;
    if (expected_reports.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected report, expected none, got status %0d type %0h length %0d",
               $time, out_ch.frame_status, out_ch.message_type, out_ch.frame_length);
      return;
    end
    want = expected_reports.pop_front();
    check_field("frame_status", 32'(want.frame_status), 32'(out_ch.frame_status));
    check_field("message_type", 32'(want.message_type), 32'(out_ch.message_type));
    check_field("frame_length", 32'(want.frame_length), 32'(out_ch.frame_length));
    check_field("is_key_frame", 32'(want.is_key_frame), 32'(out_ch.is_key_frame));
    check_field("key_value", want.key_value, out_ch.key_value);
    check_field("slider_a", 32'(want.slider_a), 32'(out_ch.slider_a));
    check_field("slider_b", 32'(want.slider_b), 32'(out_ch.slider_b));
    check_field("slider_c", 32'(want.slider_c), 32'(out_ch.slider_c));
    check_field("slider_d", 32'(want.slider_d), 32'(out_ch.slider_d));
  endfunction

  function automatic logic [7:0] data_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return ETX_BYTE;
    if (pick == 1) return STX_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void open_frame(input logic [7:0] msg_type);
    tx_bytes.delete();
    tx_bytes.push_back(STX_BYTE);
    tx_bytes.push_back(msg_type);
  endfunction

  // append crc (high byte first) and the etx run
  function automatic void seal_frame(input bit bad_crc);
    logic [15:0] crc;
    crc = '0;
    foreach (tx_bytes[i]) crc = crc_step(crc, tx_bytes[i]);
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    tx_bytes.push_back(crc[15:8]);
    tx_bytes.push_back(crc[7:0]);
    repeat (ETX_NEEDED) tx_bytes.push_back(ETX_BYTE);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    absorb_byte(b);
  endtask

  task automatic send_tx_bytes();
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ETX_BYTE);
  endtask

  task automatic test_short_frame();
    tx_bytes.delete();
    tx_bytes.push_back(STX_BYTE);
    repeat (ETX_NEEDED) tx_bytes.push_back(ETX_BYTE);
    send_tx_bytes();
  endtask

  task automatic test_key_frame();
    open_frame(KEY_TYPE);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(STX_BYTE);
    tx_bytes.push_back(8'h80);
    tx_bytes.push_back(8'h01);
    tx_bytes.push_back(8'h7F);
    tx_bytes.push_back(8'hFE);
    tx_bytes.push_back(8'h5A);
    seal_frame(1'b0);
    send_tx_bytes();
  endtask

  task automatic test_crc_error();
    open_frame(KEY_TYPE);
    tx_bytes.push_back(8'h00);
    seal_frame(1'b1);
    send_tx_bytes();
  endtask

  // longest legal frame, then one byte over
  task automatic test_length_limits();
    for (int n = MAX_FRAME - 7; n <= MAX_FRAME - 6; n++) begin
      open_frame(KEY_TYPE);
      repeat (n) tx_bytes.push_back(8'($urandom_range(0, 8'h54)));
      seal_frame(1'b0);
      send_tx_bytes();
    end
  endtask

  task automatic test_random_traffic();
    int sent;
    int kind;
    int n;
    int idx;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        if (kind >= 70) n = $urandom_range(MAX_FRAME - 6, MAX_FRAME);
        else if ($urandom_range(0, 99) < 85) n = $urandom_range(0, 12);
        else n = $urandom_range(13, MAX_FRAME - 7);
        open_frame(($urandom_range(0, 2) == 0) ? KEY_TYPE : 8'($urandom_range(0, 255)));
        repeat (n) tx_bytes.push_back(data_byte());
        seal_frame($urandom_range(0, 9) == 0);
        if (kind >= 60 && kind < 70) begin
          idx = $urandom_range(0, tx_bytes.size() - 1);
          tx_bytes[idx] = tx_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
      end else if (kind < 93) begin
        tx_bytes.delete();
        tx_bytes.push_back(STX_BYTE);
        // frames of at most seven bytes with no crc, or frames cut off without a terminator
        if (kind < 88) begin
          repeat ($urandom_range(0, 3)) tx_bytes.push_back(data_byte());
          repeat (ETX_NEEDED) tx_bytes.push_back(ETX_BYTE);
        end else begin
          repeat ($urandom_range(1, 10)) tx_bytes.push_back(data_byte());
        end
      end else begin
        tx_bytes.delete();
        repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (kind < 93) sent += tx_bytes.size();
      send_tx_bytes();
    end
  endtask

  // receiver parks while the sender keeps going, so both report slots fill up
  task automatic test_output_stall();
    tx_idle_on   = 1'b0;
    park_request = 1'b1;
    repeat (10) begin
      open_frame(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) tx_bytes.push_back(data_byte());
      seal_frame(1'b0);
      send_tx_bytes();
    end
  endtask

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (park_request) begin
        park_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (PARK_CYCLES) @(negedge clk);
      end
      gap = rx_idle_on ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_report();
      if ($urandom_range(0, 15) == 0) rx_idle_on = !rx_idle_on;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL frame_receiver_crc16_check_top");
    $finish;
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    rst_n         <= 1'b0;
    restart_msg();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_ignored_bytes();
    test_short_frame();
    test_key_frame();
    test_crc_error();
    test_length_limits();
    test_random_traffic();
    test_output_stall();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS frame_receiver_crc16_check_top");
    end else begin
      $display("FAIL frame_receiver_crc16_check_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/frc16_pkg.sv
hw/rtl/frc16_if.sv
hw/rtl/frc16_parser.sv
hw/rtl/frc16_outbuf.sv
hw/rtl/frame_receiver_crc16_check_top.sv
bench/frame_receiver_crc16_check_top_tb.sv
